### design/postfix_predicate_evaluator_defines.svh
// ----------------------------------------------------------------------------
// postfix_predicate_evaluator_defines
// Assertion macros shared by the postfix predicate evaluator.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_PREDICATE_EVALUATOR_DEFINES_SVH
`define POSTFIX_PREDICATE_EVALUATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define PPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// Codes, types and the relation function of the postfix predicate evaluator.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned ACT_W = 3;
  localparam int unsigned REL_W = 3;
  localparam int unsigned STS_W = 2;

  localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CMP  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_AND  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_OR   = 3'd3;

  localparam logic [REL_W-1:0] REL_GT = 3'd0;
  localparam logic [REL_W-1:0] REL_GE = 3'd1;
  localparam logic [REL_W-1:0] REL_LT = 3'd2;
  localparam logic [REL_W-1:0] REL_LE = 3'd3;
  localparam logic [REL_W-1:0] REL_EQ = 3'd4;
  localparam logic [REL_W-1:0] REL_NE = 3'd5;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_UNDER = 2'd1;
  localparam logic [STS_W-1:0] STS_OVER  = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic push;   // move one slot deeper, top takes new value
    logic pop;    // move one slot up, top takes combined value
  } cell_ctrl_t;

  typedef struct packed {
    logic             match;
    logic [STS_W-1:0] status;
  } result_t;

  function automatic logic relate(input logic [REL_W-1:0] rel,
                                  input val_t lhs, input val_t rhs);
    logic r;
    case (rel)
      REL_GT:  r = lhs >  rhs;
      REL_GE:  r = lhs >= rhs;
      REL_LT:  r = lhs <  rhs;
      REL_LE:  r = lhs <= rhs;
      REL_EQ:  r = lhs == rhs;
      REL_NE:  r = lhs != rhs;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### design/ppe_cell.sv
// ----------------------------------------------------------------------------
// ppe_cell
// One stack slot: takes the shallower neighbor on push, the deeper on pop.
// ----------------------------------------------------------------------------
module ppe_cell (
  input  logic                clk,
  input  ppe_pkg::cell_ctrl_t ctrl,
  input  ppe_pkg::val_t       push_in,
  input  ppe_pkg::val_t       pop_in,
  output ppe_pkg::val_t       val
);

  ppe_pkg::val_t val_r;
  ppe_pkg::val_t val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.push) begin
      val_nxt = push_in;
    end else if (ctrl.pop) begin
      val_nxt = pop_in;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

### design/ppe_outbuf.sv
// ----------------------------------------------------------------------------
// ppe_outbuf
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module ppe_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  ppe_pkg::result_t res_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output ppe_pkg::result_t out_data
);

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             skid_valid_r;
  logic             skid_valid_nxt;
  ppe_pkg::result_t out_data_r;
  ppe_pkg::result_t out_data_nxt;
  ppe_pkg::result_t skid_data_r;
  ppe_pkg::result_t skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res_data;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/postfix_predicate_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_predicate_evaluator
// Postfix row-filter predicate evaluator on a shifting value stack.
// ----------------------------------------------------------------------------
// Takes one token per clock cycle with no bubbles: the stack is a row of
// STACK_DEPTH cells with the top in cell 0, every token shifts the row by at
// most one slot, and compare/and/or only read cells 0 and 1. The result of a
// token marked tlast appears on the out_ side in the cycle after its transfer
// when the output register is free, later while the receiver holds off;
// a two-entry result buffer keeps input flowing while a result waits, and
// in_tready drops only when both entries are full.
module postfix_predicate_evaluator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand_value
  input  logic [5:0]  in_tuser,   // [2:0] action, [5:3] relation
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] match, [7:1] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  `include "postfix_predicate_evaluator_defines.svh"

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  logic                      in_fire;
  logic [ppe_pkg::ACT_W-1:0] action;
  logic [ppe_pkg::REL_W-1:0] relation;
  ppe_pkg::val_t             operand;

  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          cnt_nxt;
  logic [ppe_pkg::STS_W-1:0] err_r;
  logic [ppe_pkg::STS_W-1:0] err_nxt;

  ppe_pkg::cell_ctrl_t       ctrl;
  ppe_pkg::val_t             cell_val [STACK_DEPTH];
  ppe_pkg::val_t             push_in  [STACK_DEPTH];
  ppe_pkg::val_t             pop_in   [STACK_DEPTH];
  ppe_pkg::val_t             comb_val;
  ppe_pkg::val_t             top_nxt;
  logic                      comb_bit;
  logic                      lhs_nz;
  logic                      rhs_nz;

  logic                      res_valid;
  ppe_pkg::result_t          res_data;
  ppe_pkg::result_t          out_data;
  logic                      buf_space;

  assign in_tready = buf_space;
  assign in_fire   = in_tvalid && in_tready;
  assign action    = in_tuser[2:0];
  assign relation  = in_tuser[5:3];
  assign operand   = in_tdata;

  assign rhs_nz = cell_val[0] != '0;
  assign lhs_nz = cell_val[1] != '0;

  always_comb begin
    comb_bit = 1'b0;
    case (action)
      ppe_pkg::ACT_CMP: comb_bit = ppe_pkg::relate(relation, cell_val[1], cell_val[0]);
      ppe_pkg::ACT_AND: comb_bit = lhs_nz && rhs_nz;
      ppe_pkg::ACT_OR:  comb_bit = lhs_nz || rhs_nz;
      default:          comb_bit = 1'b0;
    endcase
  end

  assign comb_val = {{(ppe_pkg::VAL_W-1){1'b0}}, comb_bit};

  always_comb begin
    ctrl    = '0;
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    if (in_fire && err_r == ppe_pkg::STS_OK) begin
      unique case (action) inside
        ppe_pkg::ACT_PUSH: begin
          if (cnt_r == CNT_W'(STACK_DEPTH)) begin
            err_nxt = ppe_pkg::STS_OVER;
          end else begin
            ctrl.push = 1'b1;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
        end
        ppe_pkg::ACT_CMP, ppe_pkg::ACT_AND, ppe_pkg::ACT_OR: begin
          if (cnt_r < CNT_W'(2)) begin
            err_nxt = ppe_pkg::STS_UNDER;
          end else begin
            ctrl.pop = 1'b1;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    top_nxt = cell_val[0];
    if (ctrl.push) begin
      top_nxt = operand;
    end else if (ctrl.pop) begin
      top_nxt = comb_val;
    end
  end

  assign res_valid       = in_fire && in_tlast;
  assign res_data.status = err_nxt;
  assign res_data.match  = (err_nxt == ppe_pkg::STS_OK) && (cnt_nxt != '0) && (top_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= ppe_pkg::STS_OK;
    end else if (res_valid) begin
      cnt_r <= '0;
      err_r <= ppe_pkg::STS_OK;
    end else begin
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_top
        assign push_in[gi] = operand;
        assign pop_in[gi]  = comb_val;
      end else if (gi == STACK_DEPTH - 1) begin : g_bottom
        assign push_in[gi] = cell_val[gi-1];
        assign pop_in[gi]  = cell_val[gi];
      end else begin : g_mid
        assign push_in[gi] = cell_val[gi-1];
        assign pop_in[gi]  = cell_val[gi+1];
      end
      ppe_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .push_in (push_in[gi]),
        .pop_in  (pop_in[gi]),
        .val     (cell_val[gi])
      );
    end
  endgenerate

  ppe_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .space     (buf_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tdata = {7'b0, out_data.match};
  assign out_tuser = out_data.status;

  `PPE_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(STACK_DEPTH))
  `PPE_ASSERT_NEXT(a_last_gives_result, clk, rst_n, in_fire && in_tlast, out_tvalid)
  `PPE_ASSERT_NEXT(a_err_sticky, clk, rst_n, in_fire && !in_tlast && err_r != ppe_pkg::STS_OK, err_r == $past(err_r) && cnt_r == $past(cnt_r))
  `PPE_ASSERT_NEXT(a_push_grows, clk, rst_n, in_fire && !in_tlast && ctrl.push, cnt_r == $past(cnt_r) + CNT_W'(1))

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the postfix predicate evaluator. Tokens are driven on
// the in_ side with random gaps, except in the backpressure and back-to-back
// tests. An independent stack model predicts match and status for every
// closing token. Results on the out_ side are checked in order, under random
// and long receiver stalls.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [ppe_pkg::ACT_W-1:0] act_t;
  typedef logic [ppe_pkg::REL_W-1:0] rel_t;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam act_t ACT_NOP = 3'd4;
  localparam act_t ACT_TOP = 3'd7;
  localparam rel_t REL_BAD_LO = 3'd6;
  localparam rel_t REL_BAD_HI = 3'd7;
  localparam ppe_pkg::val_t VAL_MAX = 32'sh7fffffff;
  localparam ppe_pkg::val_t VAL_MIN = 32'sh80000000;

  typedef struct {
    act_t          act;
    rel_t          rel;
    ppe_pkg::val_t opnd;
  } token_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [31:0] in_tdata = '0;
  logic [5:0] in_tuser = '0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;

  postfix_predicate_evaluator #(.STACK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // stack model state
  ppe_pkg::val_t             model_stack [DEPTH];
  int unsigned               model_depth = 0;
  logic [ppe_pkg::STS_W-1:0] model_err = ppe_pkg::STS_OK;

  ppe_pkg::result_t pending_verdicts [$];
  int unsigned      tokens_taken = 0;
  int unsigned      tokens_sent = 0;
  int unsigned      n_fail = 0;
  int unsigned      cycles = 0;
  int unsigned      in_idle_pct = 35;
  int unsigned      out_idle_pct = 35;
  int unsigned      hold_left = 0;
  ppe_pkg::val_t    last_operand = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void apply_token(token_t t, logic closing);
    ppe_pkg::val_t    lhs;
    ppe_pkg::val_t    rhs;
    logic             truth;
    ppe_pkg::result_t verdict;
    if (model_err == ppe_pkg::STS_OK) begin
      if (t.act == ppe_pkg::ACT_PUSH) begin
        if (model_depth >= DEPTH) begin
          model_err = ppe_pkg::STS_OVER;
        end else begin
          model_stack[model_depth] = t.opnd;
          model_depth++;
        end
      end else if (t.act == ppe_pkg::ACT_CMP || t.act == ppe_pkg::ACT_AND ||
                   t.act == ppe_pkg::ACT_OR) begin
        if (model_depth < 2) begin
          model_err = ppe_pkg::STS_UNDER;
        end else begin
          lhs = model_stack[model_depth-2];
          rhs = model_stack[model_depth-1];
          if (t.act == ppe_pkg::ACT_AND) begin
            truth = (lhs != 0) && (rhs != 0);
          end else if (t.act == ppe_pkg::ACT_OR) begin
            truth = (lhs != 0) || (rhs != 0);
          end else begin
            case (t.rel)
              ppe_pkg::REL_GT: truth = lhs > rhs;
              ppe_pkg::REL_GE: truth = lhs >= rhs;
              ppe_pkg::REL_LT: truth = lhs < rhs;
              ppe_pkg::REL_LE: truth = lhs <= rhs;
              ppe_pkg::REL_EQ: truth = lhs == rhs;
              ppe_pkg::REL_NE: truth = lhs != rhs;
              default:         truth = 1'b0;
            endcase
          end
          model_depth--;
          model_stack[model_depth-1] = {31'b0, truth};
        end
      end
    end
    if (closing) begin
      verdict.match = (model_err == ppe_pkg::STS_OK) && (model_depth > 0) &&
                      (model_stack[model_depth-1] != 0);
      verdict.status = model_err;
      pending_verdicts = {pending_verdicts, verdict};
      model_depth = 0;
      model_err = ppe_pkg::STS_OK;
    end
  endfunction

  // input prediction and output checking on the same edge
  always @(posedge clk) begin
    token_t           t;
    ppe_pkg::result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        t.act = in_tuser[2:0];
        t.rel = in_tuser[5:3];
        t.opnd = in_tdata;
        apply_token(t, in_tlast);
        tokens_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (pending_verdicts.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected transfer: tdata=%h tuser=%0d", out_tdata, out_tuser);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_tdata !== {7'b0, want.match} || out_tuser !== want.status) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: expected match=%0d status=%0d, got tdata=%h status=%0d",
                       want.match, want.status, out_tdata, out_tuser);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= out_idle_pct);
    end
  end

  // called and returns at a falling edge
  task automatic send_token(token_t t, logic closing);
    int unsigned seen;
    while ($urandom_range(99) < in_idle_pct) @(negedge clk);
    in_tdata = t.opnd;
    in_tuser = {t.rel, t.act};
    in_tlast = closing;
    in_tvalid = 1'b1;
    seen = tokens_taken;
    do @(negedge clk); while (tokens_taken == seen);
    in_tvalid = 1'b0;
    tokens_sent++;
  endtask

  task automatic send_fields(act_t act, rel_t rel, ppe_pkg::val_t v, logic closing);
    token_t t;
    t.act = act;
    t.rel = rel;
    t.opnd = v;
    send_token(t, closing);
  endtask

  task automatic wait_drained();
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic ppe_pkg::val_t pick_operand();
    ppe_pkg::val_t v;
    case ($urandom_range(9)) inside
      0:       v = VAL_MAX;
      1:       v = VAL_MIN;
      2:       v = '0;
      [3:5]:   v = int'($urandom_range(6)) - 3;
      6:       v = last_operand;
      default: v = $urandom();
    endcase
    last_operand = v;
    return v;
  endfunction

  function automatic token_t pick_operator();
    token_t t;
    case ($urandom_range(3))
      0:       t.act = ppe_pkg::ACT_AND;
      1:       t.act = ppe_pkg::ACT_OR;
      default: t.act = ppe_pkg::ACT_CMP;
    endcase
    if ($urandom_range(9) == 0)
      t.rel = rel_t'($urandom_range(REL_BAD_LO, REL_BAD_HI));
    else
      t.rel = rel_t'($urandom_range(ppe_pkg::REL_GT, ppe_pkg::REL_NE));
    t.opnd = $urandom();
    return t;
  endfunction

  task automatic send_random_expr();
    token_t      expr [$];
    token_t      t;
    int unsigned kind;
    int unsigned n_push;
    int unsigned pushed;
    int unsigned live;
    kind = $urandom_range(99);
    if (kind < 82) begin
      n_push = (kind < 6) ? $urandom_range(15, 18) : $urandom_range(1, 6);
      pushed = 0;
      live = 0;
      while (pushed < n_push || live > 1) begin
        if (pushed < n_push && (live < 2 || kind < 6 || $urandom_range(1) == 0)) begin
          t.act = ppe_pkg::ACT_PUSH;
          t.rel = rel_t'($urandom_range(REL_BAD_HI));
          t.opnd = pick_operand();
          pushed++;
          live++;
        end else begin
          t = pick_operator();
          live--;
        end
        expr = {expr, t};
        if ($urandom_range(19) == 0) begin
          t.act = act_t'($urandom_range(ACT_NOP, ACT_TOP));
          t.rel = rel_t'($urandom_range(REL_BAD_HI));
          t.opnd = $urandom();
          expr = {expr, t};
        end
      end
    end else begin
      // broken or noisy token runs, empty expressions among them
      repeat ($urandom_range(1, 6)) begin
        t.act = act_t'($urandom_range(ACT_TOP));
        t.rel = rel_t'($urandom_range(REL_BAD_HI));
        t.opnd = pick_operand();
        expr = {expr, t};
      end
    end
    foreach (expr[i]) send_token(expr[i], i == expr.size() - 1);
  endtask

  task automatic test_compare_extremes();
    send_fields(ppe_pkg::ACT_PUSH, ppe_pkg::REL_GT, VAL_MAX, 1'b0);
    send_fields(ppe_pkg::ACT_PUSH, ppe_pkg::REL_NE, VAL_MIN, 1'b0);
    send_fields(ppe_pkg::ACT_CMP, ppe_pkg::REL_GT, 32'sh0, 1'b1);
    // unknown relation still pops two
    send_fields(ppe_pkg::ACT_PUSH, REL_BAD_HI, VAL_MIN, 1'b0);
    send_fields(ppe_pkg::ACT_PUSH, REL_BAD_LO, VAL_MIN, 1'b0);
    send_fields(ppe_pkg::ACT_CMP, REL_BAD_HI, VAL_MAX, 1'b1);
  endtask

  task automatic test_logic_and_noops();
    send_fields(ppe_pkg::ACT_PUSH, ppe_pkg::REL_LE, '0, 1'b0);
    send_fields(ppe_pkg::ACT_PUSH, ppe_pkg::REL_EQ, -32'sd1, 1'b0);
    send_fields(ACT_TOP, ppe_pkg::REL_GE, VAL_MAX, 1'b0);
    send_fields(ppe_pkg::ACT_OR, ppe_pkg::REL_LT, VAL_MIN, 1'b1);
    send_fields(ppe_pkg::ACT_PUSH, ppe_pkg::REL_GT, 32'sd5, 1'b0);
    send_fields(ppe_pkg::ACT_PUSH, ppe_pkg::REL_GT, 32'sd3, 1'b0);
    send_fields(ppe_pkg::ACT_AND, ppe_pkg::REL_GT, '0, 1'b0);
    send_fields(ACT_NOP, ppe_pkg::REL_GT, '0, 1'b1);
    // empty stack at close
    send_fields(ACT_NOP, ppe_pkg::REL_EQ, '0, 1'b1);
  endtask

  task automatic test_stack_errors();
    send_fields(ppe_pkg::ACT_PUSH, ppe_pkg::REL_GT, 32'sd1, 1'b0);
    send_fields(ppe_pkg::ACT_CMP, ppe_pkg::REL_EQ, '0, 1'b0);
    send_fields(ppe_pkg::ACT_PUSH, ppe_pkg::REL_GT, 32'sd7, 1'b1);
    send_fields(ppe_pkg::ACT_AND, ppe_pkg::REL_GT, '0, 1'b1);
  endtask

  task automatic test_output_backpressure();
    in_idle_pct = 0;
    hold_left = 80;
    repeat (40)
      send_fields(ppe_pkg::ACT_PUSH, rel_t'($urandom_range(REL_BAD_HI)), pick_operand(), 1'b1);
    in_idle_pct = 35;
  endtask

  task automatic test_back_to_back();
    int unsigned goal;
    goal = tokens_sent + 350;
    in_idle_pct = 0;
    out_idle_pct = 0;
    while (tokens_sent < goal) send_random_expr();
    in_idle_pct = 35;
    out_idle_pct = 35;
  endtask

  task automatic test_random_mix();
    int unsigned goal;
    goal = tokens_sent + 1420;
    while (tokens_sent < goal) send_random_expr();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_compare_extremes();
    test_logic_and_noops();
    test_stack_errors();
    wait_drained();
    test_output_backpressure();
    wait_drained();
    test_back_to_back();
    wait_drained();
    test_random_mix();
    wait_drained();
    repeat (10) @(negedge clk);
    if (n_fail == 0 && pending_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
